[sv/bcpc_pkg.sv]
// ----------------------------------------------------------------------------
// bcpc_pkg
// Shared types, constants and helpers of the box corner plane contact unit.
// ----------------------------------------------------------------------------
package bcpc_pkg;

    localparam int NUM_CORNERS = 8;
    localparam int CORNER_W    = $clog2(NUM_CORNERS);

    localparam int Q_W         = 16;  // Q7.8 positions, Q1.14 rotation/normal
    localparam int ROW_W       = 3 * Q_W;
    localparam int DIM_W       = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int PROD_W      = 2 * Q_W;      // rotation * local, Q.23
    localparam int ACC_W       = PROD_W + 2;   // centre + three products
    localparam int DIFF_W      = Q_W + 1;      // corner - plane
    localparam int DPROD_W     = DIFF_W + Q_W; // Q.22
    localparam int DIST_W      = DPROD_W + 2;  // sum of three
    localparam int SAT_IN_W    = 24;

    localparam logic signed [Q_W-1:0] NORMAL_Y_RST = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_X  = 3'd0,
        CFG_PLANE_Y  = 3'd1,
        CFG_PLANE_Z  = 3'd2,
        CFG_NORMAL_X = 3'd3,
        CFG_NORMAL_Y = 3'd4,
        CFG_NORMAL_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                valid;
        logic [CORNER_W-1:0] corner;
        logic                last;
    } t_ctl;

    typedef logic signed [Q_W-1:0] t_q;

    function automatic t_q sat16(input logic signed [SAT_IN_W-1:0] v);
        t_q res;
        if (v > 24'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

[sv/bcpc_corner_seq.sv]
// ----------------------------------------------------------------------------
// bcpc_corner_seq
// Holds one box and issues its eight corners, one per advancing cycle.
// ----------------------------------------------------------------------------
module bcpc_corner_seq (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_adv,
    input  logic [bcpc_pkg::ROW_W-1:0]           i_rot_row0,
    input  logic [bcpc_pkg::ROW_W-1:0]           i_rot_row1,
    input  logic [bcpc_pkg::ROW_W-1:0]           i_rot_row2,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_box_pos_x,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_box_pos_y,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_box_pos_z,
    input  logic [bcpc_pkg::DIM_W-1:0]           i_dim_x,
    input  logic [bcpc_pkg::DIM_W-1:0]           i_dim_y,
    input  logic [bcpc_pkg::DIM_W-1:0]           i_dim_z,
    output bcpc_pkg::t_ctl                       o_ctl,
    output logic [bcpc_pkg::ROW_W-1:0]           o_rot_row0,
    output logic [bcpc_pkg::ROW_W-1:0]           o_rot_row1,
    output logic [bcpc_pkg::ROW_W-1:0]           o_rot_row2,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_box_pos_x,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_box_pos_y,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_box_pos_z,
    output logic [bcpc_pkg::DIM_W-1:0]           o_dim_x,
    output logic [bcpc_pkg::DIM_W-1:0]           o_dim_y,
    output logic [bcpc_pkg::DIM_W-1:0]           o_dim_z
);

    localparam logic [bcpc_pkg::CORNER_W-1:0] LAST_CORNER =
        bcpc_pkg::CORNER_W'(bcpc_pkg::NUM_CORNERS - 1);

    logic                          r_busy, n_busy;
    logic [bcpc_pkg::CORNER_W-1:0] r_cnt, n_cnt;
    logic [bcpc_pkg::ROW_W-1:0]    r_row0, r_row1, r_row2;
    logic signed [bcpc_pkg::Q_W-1:0] r_px, r_py, r_pz;
    logic [bcpc_pkg::DIM_W-1:0]    r_dx, r_dy, r_dz;

    logic issue, done, accept;

    always_comb begin
        issue   = r_busy && i_adv;
        done    = issue && (r_cnt == LAST_CORNER);
        o_stall = r_busy && !done;
        accept  = i_valid && !o_stall;
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (accept) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (issue) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // box payload, loaded on the input transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row0 <= i_rot_row0;
            r_row1 <= i_rot_row1;
            r_row2 <= i_rot_row2;
            r_px   <= i_box_pos_x;
            r_py   <= i_box_pos_y;
            r_pz   <= i_box_pos_z;
            r_dx   <= i_dim_x;
            r_dy   <= i_dim_y;
            r_dz   <= i_dim_z;
        end
    end

    always_comb begin
        o_ctl.valid  = r_busy;
        o_ctl.corner = r_cnt;
        o_ctl.last   = (r_cnt == LAST_CORNER);
        o_rot_row0   = r_row0;
        o_rot_row1   = r_row1;
        o_rot_row2   = r_row2;
        o_box_pos_x  = r_px;
        o_box_pos_y  = r_py;
        o_box_pos_z  = r_pz;
        o_dim_x      = r_dx;
        o_dim_y      = r_dy;
        o_dim_z      = r_dz;
    end

endmodule

[sv/bcpc_xform.sv]
// ----------------------------------------------------------------------------
// bcpc_xform
// Two stages: rotate the signed half-lengths, then add the centre, round to
// Q7.8 and saturate.
// ----------------------------------------------------------------------------
module bcpc_xform (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  bcpc_pkg::t_ctl                       i_ctl,
    input  logic [bcpc_pkg::ROW_W-1:0]           i_rot_row0,
    input  logic [bcpc_pkg::ROW_W-1:0]           i_rot_row1,
    input  logic [bcpc_pkg::ROW_W-1:0]           i_rot_row2,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_box_pos_x,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_box_pos_y,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_box_pos_z,
    input  logic [bcpc_pkg::DIM_W-1:0]           i_dim_x,
    input  logic [bcpc_pkg::DIM_W-1:0]           i_dim_y,
    input  logic [bcpc_pkg::DIM_W-1:0]           i_dim_z,
    output bcpc_pkg::t_ctl                       o_ctl,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_pos_x,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_pos_y,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_pos_z
);

    localparam int QW = bcpc_pkg::Q_W;
    localparam int AW = bcpc_pkg::ACC_W;
    localparam logic signed [AW-1:0] HALF_LSB = AW'(1) <<< 14;

    logic [bcpc_pkg::ROW_W-1:0]   rows [3];
    logic signed [QW-1:0]         rot  [3][3];
    logic signed [QW-1:0]         lcl  [3];
    logic [bcpc_pkg::DIM_W-1:0]   dims [3];
    logic signed [QW-1:0]         ctr  [3];

    logic signed [bcpc_pkg::PROD_W-1:0] r_prod [3][3];
    logic signed [QW-1:0]               r_s1_ctr [3];
    bcpc_pkg::t_ctl                     r_s1_ctl, r_s2_ctl;
    logic signed [QW-1:0]               r_pos [3];

    logic signed [AW-1:0]   acc [3];
    logic signed [QW-1:0]   n_pos [3];

    always_comb begin
        rows[0] = i_rot_row0;
        rows[1] = i_rot_row1;
        rows[2] = i_rot_row2;
        dims[0] = i_dim_x;
        dims[1] = i_dim_y;
        dims[2] = i_dim_z;
        ctr[0]  = i_box_pos_x;
        ctr[1]  = i_box_pos_y;
        ctr[2]  = i_box_pos_z;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                rot[r][c] = rows[r][QW*c +: QW];
            end
        end
        // corner bit 2 picks x, bit 1 y, bit 0 z; set means positive
        for (int c = 0; c < 3; c++) begin
            if (i_ctl.corner[2-c]) begin
                lcl[c] = $signed({1'b0, dims[c]});
            end else begin
                lcl[c] = -$signed({1'b0, dims[c]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= rot[r][c] * lcl[c];
                end
                r_s1_ctr[r] <= ctr[r];
            end
        end
    end

    // sum in Q.23, round to nearest with ties up, saturate
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = (AW'(r_s1_ctr[r]) <<< 15) + AW'(r_prod[r][0])
                   + AW'(r_prod[r][1]) + AW'(r_prod[r][2]) + HALF_LSB;
            n_pos[r] = bcpc_pkg::sat16(bcpc_pkg::SAT_IN_W'($signed(acc[r][AW-1:15])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_pos[r] <= n_pos[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
        end else if (i_adv) begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
        end
    end

    always_comb begin
        o_ctl   = r_s2_ctl;
        o_pos_x = r_pos[0];
        o_pos_y = r_pos[1];
        o_pos_z = r_pos[2];
    end

endmodule

[sv/bcpc_plane.sv]
// ----------------------------------------------------------------------------
// bcpc_plane
// Two stages: per-axis distance products, then the sum, hit decision, depth
// rounding and the output register that faces the result channel.
// ----------------------------------------------------------------------------
module bcpc_plane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_stall,
    output logic                                 o_adv,
    input  bcpc_pkg::t_ctl                       i_ctl,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_pos_x,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_pos_y,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_pos_z,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_plane_x,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_plane_y,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_plane_z,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_normal_x,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_normal_y,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_normal_z,
    output logic                                 o_valid,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_contact_x,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_contact_y,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_contact_z,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_depth,
    output logic [bcpc_pkg::CORNER_W-1:0]        o_corner,
    output logic                                 o_hit,
    output logic                                 o_last
);

    localparam int QW = bcpc_pkg::Q_W;
    localparam int DW = bcpc_pkg::DIST_W;
    localparam logic signed [DW-1:0] HALF_LSB = DW'(1) <<< 13;

    logic signed [QW-1:0]                pos [3];
    logic signed [QW-1:0]                pln [3];
    logic signed [QW-1:0]                nrm [3];
    logic signed [bcpc_pkg::DIFF_W-1:0]  diff [3];

    logic signed [bcpc_pkg::DPROD_W-1:0] r_dprod [3];
    logic signed [QW-1:0]                r_s3_pos [3];
    bcpc_pkg::t_ctl                      r_s3_ctl;

    logic signed [DW-1:0]  sdist, rnd;
    logic signed [QW-1:0]  dq;
    logic signed [QW-1:0]  n_depth;
    logic                  n_hit;

    logic                          r_out_valid;
    logic signed [QW-1:0]          r_out_pos [3];
    logic signed [QW-1:0]          r_out_depth;
    logic [bcpc_pkg::CORNER_W-1:0] r_out_corner;
    logic                          r_out_hit, r_out_last;

    // the whole pipe moves whenever the output register is free or taken
    assign o_adv = !r_out_valid || !i_stall;

    always_comb begin
        pos[0] = i_pos_x;
        pos[1] = i_pos_y;
        pos[2] = i_pos_z;
        pln[0] = i_plane_x;
        pln[1] = i_plane_y;
        pln[2] = i_plane_z;
        nrm[0] = i_normal_x;
        nrm[1] = i_normal_y;
        nrm[2] = i_normal_z;
        for (int r = 0; r < 3; r++) begin
            diff[r] = bcpc_pkg::DIFF_W'(pos[r]) - bcpc_pkg::DIFF_W'(pln[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_dprod[r]  <= diff[r] * nrm[r];
                r_s3_pos[r] <= pos[r];
            end
        end
    end

    // exact Q.22 distance decides the hit; depth is rounded from it
    always_comb begin
        sdist = DW'(r_dprod[0]) + DW'(r_dprod[1]) + DW'(r_dprod[2]);
        n_hit = sdist[DW-1];
        rnd   = sdist + HALF_LSB;
        dq    = bcpc_pkg::sat16(bcpc_pkg::SAT_IN_W'($signed(rnd[DW-1:14])));
        if (!n_hit) begin
            n_depth = '0;
        end else if (dq > 16'sd0) begin
            n_depth = '0;
        end else begin
            n_depth = dq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_out_pos[r] <= r_s3_pos[r];
            end
            r_out_depth  <= n_depth;
            r_out_corner <= r_s3_ctl.corner;
            r_out_hit    <= n_hit;
            r_out_last   <= r_s3_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl    <= '0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_s3_ctl    <= i_ctl;
            r_out_valid <= r_s3_ctl.valid;
        end
    end

    always_comb begin
        o_valid     = r_out_valid;
        o_contact_x = r_out_pos[0];
        o_contact_y = r_out_pos[1];
        o_contact_z = r_out_pos[2];
        o_depth     = r_out_depth;
        o_corner    = r_out_corner;
        o_hit       = r_out_hit;
        o_last      = r_out_last;
    end

endmodule

[sv/box_corner_plane_contact_unit.sv]
// ----------------------------------------------------------------------------
// box_corner_plane_contact_unit
// Oriented box against plane: one result per box corner with world position,
// penetration depth and hit flag.
// ----------------------------------------------------------------------------
// Each accepted box yields eight corner results in corner order 0 to 7, one
// per cycle unless the result side stalls; the corner sequencer, issuing one
// corner per advancing cycle, sets that rate. The next box is accepted in the
// cycle its predecessor's last corner is issued. A box's first result passes
// the sequencer's box register, then the rotate, sum/round, distance product
// and sum/depth registers. A stall on the result side freezes the whole pipe
// without loss. Plane and normal registers are written through the config
// port, by the user only while the unit is idle; the block does not enforce it.
module box_corner_plane_contact_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // box input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [bcpc_pkg::ROW_W-1:0]           i_rot_row0,
    input  logic [bcpc_pkg::ROW_W-1:0]           i_rot_row1,
    input  logic [bcpc_pkg::ROW_W-1:0]           i_rot_row2,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_box_pos_x,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_box_pos_y,
    input  logic signed [bcpc_pkg::Q_W-1:0]      i_box_pos_z,
    input  logic [bcpc_pkg::DIM_W-1:0]           i_dim_x,
    input  logic [bcpc_pkg::DIM_W-1:0]           i_dim_y,
    input  logic [bcpc_pkg::DIM_W-1:0]           i_dim_z,
    // corner result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_contact_x,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_contact_y,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_contact_z,
    output logic signed [bcpc_pkg::Q_W-1:0]      o_depth,
    output logic [bcpc_pkg::CORNER_W-1:0]        o_corner,
    output logic                                 o_hit,
    output logic                                 o_last,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [bcpc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bcpc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic signed [bcpc_pkg::Q_W-1:0] r_plane_x, r_plane_y, r_plane_z;
    logic signed [bcpc_pkg::Q_W-1:0] r_normal_x, r_normal_y, r_normal_z;

    logic                            adv;
    bcpc_pkg::t_ctl                  seq_ctl, xf_ctl;
    logic [bcpc_pkg::ROW_W-1:0]      seq_row0, seq_row1, seq_row2;
    logic signed [bcpc_pkg::Q_W-1:0] seq_px, seq_py, seq_pz;
    logic [bcpc_pkg::DIM_W-1:0]      seq_dx, seq_dy, seq_dz;
    logic signed [bcpc_pkg::Q_W-1:0] xf_px, xf_py, xf_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_x  <= '0;
            r_plane_y  <= '0;
            r_plane_z  <= '0;
            r_normal_x <= '0;
            r_normal_y <= bcpc_pkg::NORMAL_Y_RST;
            r_normal_z <= '0;
        end else if (i_cfg_we) begin
            unique case (bcpc_pkg::t_cfg_idx'(i_cfg_idx))
                bcpc_pkg::CFG_PLANE_X:  r_plane_x  <= i_cfg_data;
                bcpc_pkg::CFG_PLANE_Y:  r_plane_y  <= i_cfg_data;
                bcpc_pkg::CFG_PLANE_Z:  r_plane_z  <= i_cfg_data;
                bcpc_pkg::CFG_NORMAL_X: r_normal_x <= i_cfg_data;
                bcpc_pkg::CFG_NORMAL_Y: r_normal_y <= i_cfg_data;
                bcpc_pkg::CFG_NORMAL_Z: r_normal_z <= i_cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    bcpc_corner_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_adv       (adv),
        .i_rot_row0  (i_rot_row0),
        .i_rot_row1  (i_rot_row1),
        .i_rot_row2  (i_rot_row2),
        .i_box_pos_x (i_box_pos_x),
        .i_box_pos_y (i_box_pos_y),
        .i_box_pos_z (i_box_pos_z),
        .i_dim_x     (i_dim_x),
        .i_dim_y     (i_dim_y),
        .i_dim_z     (i_dim_z),
        .o_ctl       (seq_ctl),
        .o_rot_row0  (seq_row0),
        .o_rot_row1  (seq_row1),
        .o_rot_row2  (seq_row2),
        .o_box_pos_x (seq_px),
        .o_box_pos_y (seq_py),
        .o_box_pos_z (seq_pz),
        .o_dim_x     (seq_dx),
        .o_dim_y     (seq_dy),
        .o_dim_z     (seq_dz)
    );

    bcpc_xform u_xform (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_ctl       (seq_ctl),
        .i_rot_row0  (seq_row0),
        .i_rot_row1  (seq_row1),
        .i_rot_row2  (seq_row2),
        .i_box_pos_x (seq_px),
        .i_box_pos_y (seq_py),
        .i_box_pos_z (seq_pz),
        .i_dim_x     (seq_dx),
        .i_dim_y     (seq_dy),
        .i_dim_z     (seq_dz),
        .o_ctl       (xf_ctl),
        .o_pos_x     (xf_px),
        .o_pos_y     (xf_py),
        .o_pos_z     (xf_pz)
    );

    bcpc_plane u_plane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stall     (i_stall),
        .o_adv       (adv),
        .i_ctl       (xf_ctl),
        .i_pos_x     (xf_px),
        .i_pos_y     (xf_py),
        .i_pos_z     (xf_pz),
        .i_plane_x   (r_plane_x),
        .i_plane_y   (r_plane_y),
        .i_plane_z   (r_plane_z),
        .i_normal_x  (r_normal_x),
        .i_normal_y  (r_normal_y),
        .i_normal_z  (r_normal_z),
        .o_valid     (o_valid),
        .o_contact_x (o_contact_x),
        .o_contact_y (o_contact_y),
        .o_contact_z (o_contact_z),
        .o_depth     (o_depth),
        .o_corner    (o_corner),
        .o_hit       (o_hit),
        .o_last      (o_last)
    );

endmodule

[sv/bcpc_checker.sv]
// ----------------------------------------------------------------------------
// bcpc_checker
// Port-level checks on the corner result channel of the contact unit.
// ----------------------------------------------------------------------------
module bcpc_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic signed [bcpc_pkg::Q_W-1:0]      o_contact_x,
    input  logic signed [bcpc_pkg::Q_W-1:0]      o_depth,
    input  logic [bcpc_pkg::CORNER_W-1:0]        o_corner,
    input  logic                                 o_hit,
    input  logic                                 o_last
);

    localparam logic [bcpc_pkg::CORNER_W-1:0] LAST_CORNER =
        bcpc_pkg::CORNER_W'(bcpc_pkg::NUM_CORNERS - 1);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_corner) && $stable(o_depth)
            && $stable(o_contact_x) && $stable(o_hit) && $stable(o_last))
        else $error("stalled result changed");

    // last marker only on the final corner and always there
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_corner == LAST_CORNER)))
        else $error("last marker does not match corner index");

    a_miss_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_depth == '0)
        else $error("nonzero depth on a miss");

    a_depth_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_depth[bcpc_pkg::Q_W-1] || o_depth == '0)
        else $error("positive depth");

endmodule

bind box_corner_plane_contact_unit bcpc_checker u_bcpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_contact_x (o_contact_x),
    .o_depth     (o_depth),
    .o_corner    (o_corner),
    .o_hit       (o_hit),
    .o_last      (o_last)
);
